// ===== hw/rtl/ogr_pkg.sv =====
// ---------------------------------------------------------------------------
// ogr_pkg: shared types and constants for the occupancy grid ray update
// Transfer structs, operation and register codes, and cell saturation helpers.
// ---------------------------------------------------------------------------
package ogr_pkg;

    // operation codes carried in the mode field
    localparam logic [1:0] MODE_READ = 2'd0;
    localparam logic [1:0] MODE_HIT  = 2'd1;
    localparam logic [1:0] MODE_RAY  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_STEP  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_STEP = 4'd1;

    localparam int STEP_W  = 7;
    localparam int COORD_W = 16;
    localparam int ERR_W   = 19;

    localparam logic signed [7:0] CELL_MAX = 8'sd127;
    localparam logic signed [7:0] CELL_MIN = -8'sd127;
    localparam logic [15:0] TOUCH_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
    } ogr_req_t;

    typedef struct packed {
        logic signed [7:0]  cell_value;
        logic               inside_grid;
        logic [15:0]        cells_touched;
    } ogr_rsp_t;

    // current cell of the line walker
    typedef struct packed {
        logic                       active;
        logic                       last;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } ogr_walk_t;

    // add with saturation at the upper bound
    function automatic logic signed [7:0] cell_raise(logic signed [7:0] v,
                                                     logic [STEP_W-1:0] step);
        logic signed [8:0] sum;
        sum = $signed({v[7], v}) + $signed({2'b00, step});
        if (sum > 9'sd127)
            return CELL_MAX;
        return sum[7:0];
    endfunction

    // subtract with saturation at the lower bound
    function automatic logic signed [7:0] cell_lower(logic signed [7:0] v,
                                                     logic [STEP_W-1:0] step);
        logic signed [8:0] diff;
        diff = $signed({v[7], v}) - $signed({2'b00, step});
        if (diff < -9'sd127)
            return CELL_MIN;
        return diff[7:0];
    endfunction

endpackage

// ===== hw/rtl/ogr_grid_mem.sv =====
// ---------------------------------------------------------------------------
// ogr_grid_mem: cell storage
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ogr_grid_mem #(
    parameter int AW    = 16,
    parameter int DEPTH = 65536
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic signed [7:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic signed [7:0] wr_data
);

    logic signed [7:0] grid_mem [DEPTH];
    logic signed [7:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= wr_data;
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= grid_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ogr_line_walker.sv =====
// ---------------------------------------------------------------------------
// ogr_line_walker: integer line stepper
// Presents one cell per cycle from start to end, both ends included.
// ---------------------------------------------------------------------------
module ogr_line_walker import ogr_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] sx,
    input  logic signed [COORD_W-1:0] sy,
    input  logic signed [COORD_W-1:0] ex,
    input  logic signed [COORD_W-1:0] ey,
    output ogr_walk_t                 walk
);

    logic                      active_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg, ex_reg, ey_reg;
    logic signed [ERR_W-1:0]   dx_reg, dy_reg, err_reg;
    logic                      stx_neg_reg, sty_neg_reg;

    logic signed [COORD_W:0]   diff_x, diff_y, abs_x, abs_y;
    logic signed [ERR_W-1:0]   dx_init, dy_init;
    logic signed [ERR_W:0]     e2;
    logic                      step_x, step_y, last;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [COORD_W-1:0] x_next, y_next;

    // line setup from the endpoints
    always_comb
    begin
        diff_x  = $signed({ex[COORD_W-1], ex}) - $signed({sx[COORD_W-1], sx});
        diff_y  = $signed({ey[COORD_W-1], ey}) - $signed({sy[COORD_W-1], sy});
        abs_x   = diff_x[COORD_W] ? -diff_x : diff_x;
        abs_y   = diff_y[COORD_W] ? -diff_y : diff_y;
        dx_init = $signed({3'b000, abs_x[COORD_W-1:0]});
        dy_init = $signed({3'b000, abs_y[COORD_W-1:0]});
    end

    // one error-term line step
    always_comb
    begin
        e2       = {err_reg, 1'b0};
        step_x   = e2 >= -$signed({dy_reg[ERR_W-1], dy_reg});
        step_y   = e2 <= $signed({dx_reg[ERR_W-1], dx_reg});
        err_next = err_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        if (step_x)
        begin
            err_next = err_next - dy_reg;
            x_next   = x_reg + (stx_neg_reg ? -16'sd1 : 16'sd1);
        end
        if (step_y)
        begin
            err_next = err_next + dx_reg;
            y_next   = y_reg + (sty_neg_reg ? -16'sd1 : 16'sd1);
        end
        last = active_reg && (x_reg == ex_reg) && (y_reg == ey_reg);
    end

    // walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else if (start)
            active_reg <= 1'b1;
        else if (last)
            active_reg <= 1'b0;
    end

    // position and error terms
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg       <= sx;
            y_reg       <= sy;
            ex_reg      <= ex;
            ey_reg      <= ey;
            dx_reg      <= dx_init;
            dy_reg      <= dy_init;
            err_reg     <= dx_init - dy_init;
            stx_neg_reg <= !(sx < ex);
            sty_neg_reg <= !(sy < ey);
        end
        else if (active_reg && !last)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            err_reg <= err_next;
        end
    end

    always_comb
    begin
        walk.active = active_reg;
        walk.last   = last;
        walk.x      = x_reg;
        walk.y      = y_reg;
    end

endmodule

// ===== hw/rtl/occupancy_grid_ray_update_core.sv =====
// ---------------------------------------------------------------------------
// occupancy_grid_ray_update_core: log-odds occupancy grid update engine
// Reads, scores hits on, and clears rays through a grid of signed cells.
// ---------------------------------------------------------------------------
// Usage:
//   req / req_valid / req_stall carry one operation per transfer: read the
//   end cell, add hit_step to the end cell, or walk a straight-line ray from
//   start to end subtracting miss_step from every in-grid cell.
//   rsp / rsp_valid / rsp_stall return exactly one result per operation.
//   cfg_valid / cfg_ready / cfg_index / cfg_data write hit_step (index 0)
//   and miss_step (index 1); cfg_ready is always high.
// Timing:
//   The ray walker visits one cell per cycle, with a read-modify-write of
//   the grid memory behind it (registered read data, write-back in the
//   following cycle). One operation is in flight at a time; the next is
//   taken while a result still waits on rsp_stall.
// Reset:
//   After reset a clearing pass zeroes the memory, one entry per cycle,
//   GRID_HEIGHT * 2**clog2(GRID_WIDTH) entries (65536 by default), with
//   req_stall high. Configuration writes are taken during the pass.
//   A stalled result holds; a finished operation waits until it drains.
// ---------------------------------------------------------------------------
module occupancy_grid_ray_update_core import ogr_pkg::*; #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  ogr_req_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output ogr_rsp_t             rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]    cfg_data
);

    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = GRID_HEIGHT << XW;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [STEP_W-1:0]   hit_step_reg, miss_step_reg;
    logic                rsp_valid_reg;
    logic                pipe_valid_reg;
    logic [AW-1:0]       pipe_addr_reg;
    logic [1:0]          op_reg;
    logic signed [7:0]   acc_value_reg;
    logic                acc_inside_reg;
    logic [15:0]         acc_touched_reg;
    ogr_rsp_t            rsp_data_reg;

    ogr_walk_t           walk;
    logic                req_xfer, walk_start, rsp_load, cell_in;
    logic signed [COORD_W-1:0] walk_sx, walk_sy;
    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic signed [7:0]   rd_data, wr_data, cell_new;
    logic                cell_write;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;
    assign rsp_load  = (state_reg == ST_HOLD) && (!rsp_valid_reg || !rsp_stall);

    // read and hit walk a single cell at the end point
    assign walk_start = req_xfer && (req.mode == MODE_READ || req.mode == MODE_HIT
                                     || req.mode == MODE_RAY);
    assign walk_sx    = (req.mode == MODE_RAY) ? req.start_x : req.end_x;
    assign walk_sy    = (req.mode == MODE_RAY) ? req.start_y : req.end_y;

    ogr_line_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .start (walk_start),
        .sx    (walk_sx),
        .sy    (walk_sy),
        .ex    (req.end_x),
        .ey    (req.end_y),
        .walk  (walk)
    );

    // grid bounds check and read issue for the current cell
    always_comb
    begin
        cell_in = walk.active && !walk.x[COORD_W-1] && !walk.y[COORD_W-1]
                  && (walk.x[COORD_W-2:0] < (COORD_W-1)'(GRID_WIDTH))
                  && (walk.y[COORD_W-2:0] < (COORD_W-1)'(GRID_HEIGHT));
        rd_en   = cell_in;
        rd_addr = {walk.y[YW-1:0], walk.x[XW-1:0]};
    end

    // modify stage on the returned cell
    always_comb
    begin
        cell_new   = rd_data;
        cell_write = 1'b0;
        case (op_reg)
            MODE_HIT:
            begin
                cell_new   = cell_raise(rd_data, hit_step_reg);
                cell_write = pipe_valid_reg;
            end
            MODE_RAY:
            begin
                cell_new   = cell_lower(rd_data, miss_step_reg);
                cell_write = pipe_valid_reg;
            end
            default:
            begin
                cell_new   = rd_data;
                cell_write = 1'b0;
            end
        endcase
    end

    // write port shared by clearing pass and write-back
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = 8'sd0;
        end
        else
        begin
            wr_en   = cell_write;
            wr_addr = pipe_addr_reg;
            wr_data = cell_new;
        end
    end

    ogr_grid_mem #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // sequencer, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            hit_step_reg   <= 7'd3;
            miss_step_reg  <= 7'd1;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_HIT_STEP:  hit_step_reg  <= cfg_data;
                    REG_MISS_STEP: miss_step_reg <= cfg_data;
                    default:       ;
                endcase
            end

            pipe_valid_reg <= cell_in;

            if (rsp_load)
            begin
                rsp_valid_reg              <= 1'b1;
                rsp_data_reg.cell_value    <= acc_value_reg;
                rsp_data_reg.inside_grid   <= acc_inside_reg;
                rsp_data_reg.cells_touched <= acc_touched_reg;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(DEPTH - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (walk_start)
                        state_reg <= ST_WALK;
                    else if (req_xfer)
                        state_reg <= ST_HOLD;
                end
                ST_WALK:
                begin
                    if (walk.last)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                    state_reg <= ST_HOLD;
                ST_HOLD:
                begin
                    if (rsp_load)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // pipeline address and accumulators
    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= rd_addr;
        if (req_xfer)
        begin
            op_reg          <= req.mode;
            acc_value_reg   <= 8'sd0;
            acc_inside_reg  <= 1'b0;
            acc_touched_reg <= '0;
        end
        else if (pipe_valid_reg)
        begin
            acc_inside_reg <= 1'b1;
            acc_value_reg  <= (op_reg == MODE_RAY) ? 8'sd0 : cell_new;
            if (op_reg == MODE_HIT)
                acc_touched_reg <= 16'd1;
            else if (op_reg == MODE_RAY && acc_touched_reg != TOUCH_MAX)
                acc_touched_reg <= acc_touched_reg + 16'd1;
        end
    end

    // consecutive ray cells never share an entry, so no forwarding is needed
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write of the same grid entry in one cycle");

    a_walk_in_walk_state: assert property (@(posedge clk) disable iff (!rst_n)
        walk.active |-> (state_reg == ST_WALK))
        else $error("line walker active outside the walk state");

    a_pipe_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> (state_reg == ST_WALK || state_reg == ST_DRAIN))
        else $error("modify stage busy outside an operation");

    a_inside_matches_touch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && op_reg == MODE_RAY)
            |-> (acc_inside_reg == (acc_touched_reg != 16'd0)))
        else $error("ray inside flag disagrees with touched count");

endmodule
